FILE: sv/pcdt_pkg.sv
// Shared widths, reset values, register indexes and types for the point cloud
// decimate and transform block. No dependencies; imported by every module.
package pcdt_pkg;

    localparam int IDX_W      = 20;
    localparam int COORD_W    = 24;
    localparam int DEC_W      = 8;
    localparam int BLIND_W    = 34;
    localparam int QUAT_W     = 64;
    localparam int QC_W       = 16;
    localparam int OFF_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Points at or beyond this index are dropped
    localparam int PT_CMP_W   = 25;
    localparam int MAX_POINTS = 1048576;

    // Remainder unit: quotient bits resolved per pipeline stage
    localparam int REM_BITS   = 4;
    localparam int REM_STAGES = IDX_W / REM_BITS;

    // Squared norm
    localparam int SQ_W       = 2 * COORD_W - 1;
    localparam int SQSUM_W    = SQ_W + 1;

    // Rotation datapath
    localparam int QPROD_W    = 2 * QC_W;
    localparam int MAT_W      = 34;
    localparam int VEC_W      = COORD_W + 1;
    localparam int PROD_W     = MAT_W + VEC_W;
    localparam int SUM_W      = 64;
    localparam int FRAC_W     = 30;
    localparam int RND_W      = SUM_W - FRAC_W;

    localparam logic [DEC_W-1:0]   DEC_RESET   = 8'd3;
    localparam logic [BLIND_W-1:0] BLIND_RESET = 34'd262144;
    localparam logic [QUAT_W-1:0]  QUAT_RESET  = 64'h7FFF_0000_0000_0000;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DECIMATION  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLIND_RADIUS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUATERNION  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_NORTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_EAST    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_DOWN    = 3'd5;

    typedef logic signed [MAT_W-1:0] mat_elem_t;

    // Row-major body-to-NED matrix, Q.30; rows north, east, down
    typedef struct packed {
        logic [DEC_W-1:0]          dec;
        logic [BLIND_W-1:0]        blind;
        mat_elem_t [8:0]           mat;
        logic signed [OFF_W-1:0]   off_n;
        logic signed [OFF_W-1:0]   off_e;
        logic signed [OFF_W-1:0]   off_d;
    } cfg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] f;
        logic signed [COORD_W-1:0] l;
        logic signed [COORD_W-1:0] u;
    } point_t;

endpackage

FILE: sv/pcdt_cfg.sv
// Configuration registers and rotation matrix builder.
// Depends on pcdt_pkg; feeds pcdt_filter and pcdt_xform through cfg_t.
module pcdt_cfg
    import pcdt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    localparam int P_XX = 0;
    localparam int P_YY = 1;
    localparam int P_ZZ = 2;
    localparam int P_XY = 3;
    localparam int P_WZ = 4;
    localparam int P_XZ = 5;
    localparam int P_WY = 6;
    localparam int P_YZ = 7;
    localparam int P_WX = 8;

    localparam mat_elem_t Q30_ONE = mat_elem_t'(1) <<< FRAC_W;

    logic [DEC_W-1:0]        dec_reg;
    logic [BLIND_W-1:0]      blind_reg;
    logic [QUAT_W-1:0]       quat_reg;
    logic signed [OFF_W-1:0] offn_reg;
    logic signed [OFF_W-1:0] offe_reg;
    logic signed [OFF_W-1:0] offd_reg;

    logic signed [QPROD_W-1:0] qprod_reg  [9];
    logic signed [QPROD_W-1:0] qprod_next [9];
    mat_elem_t                 mat_reg    [9];
    mat_elem_t                 mat_next   [9];

    logic signed [QC_W-1:0] qw, qx, qy, qz;
    mat_elem_t              e [9];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_reg   <= DEC_RESET;
            blind_reg <= BLIND_RESET;
            quat_reg  <= QUAT_RESET;
            offn_reg  <= '0;
            offe_reg  <= '0;
            offd_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DECIMATION:   dec_reg   <= cfg_data[DEC_W-1:0];
                CFG_BLIND_RADIUS: blind_reg <= cfg_data[BLIND_W-1:0];
                CFG_QUATERNION:   quat_reg  <= cfg_data[QUAT_W-1:0];
                CFG_OFF_NORTH:    offn_reg  <= cfg_data[OFF_W-1:0];
                CFG_OFF_EAST:     offe_reg  <= cfg_data[OFF_W-1:0];
                CFG_OFF_DOWN:     offd_reg  <= cfg_data[OFF_W-1:0];
                default:          ;
            endcase
        end
    end

    assign qw = quat_reg[4*QC_W-1:3*QC_W];
    assign qx = quat_reg[3*QC_W-1:2*QC_W];
    assign qy = quat_reg[2*QC_W-1:QC_W];
    assign qz = quat_reg[QC_W-1:0];

    always_comb
    begin
        qprod_next[P_XX] = qx * qx;
        qprod_next[P_YY] = qy * qy;
        qprod_next[P_ZZ] = qz * qz;
        qprod_next[P_XY] = qx * qy;
        qprod_next[P_WZ] = qw * qz;
        qprod_next[P_XZ] = qx * qz;
        qprod_next[P_WY] = qw * qy;
        qprod_next[P_YZ] = qy * qz;
        qprod_next[P_WX] = qw * qx;
    end

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            e[i] = mat_elem_t'(qprod_reg[i]);
        end
        mat_next[0] = Q30_ONE - ((e[P_YY] + e[P_ZZ]) <<< 1);
        mat_next[1] = (e[P_XY] - e[P_WZ]) <<< 1;
        mat_next[2] = (e[P_XZ] + e[P_WY]) <<< 1;
        mat_next[3] = (e[P_XY] + e[P_WZ]) <<< 1;
        mat_next[4] = Q30_ONE - ((e[P_XX] + e[P_ZZ]) <<< 1);
        mat_next[5] = (e[P_YZ] - e[P_WX]) <<< 1;
        mat_next[6] = (e[P_XZ] - e[P_WY]) <<< 1;
        mat_next[7] = (e[P_YZ] + e[P_WX]) <<< 1;
        mat_next[8] = Q30_ONE - ((e[P_XX] + e[P_YY]) <<< 1);
    end

    // Quaternion products are registered, then the matrix built from them
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 9; i++)
        begin
            qprod_reg[i] <= qprod_next[i];
            mat_reg[i]   <= mat_next[i];
        end
    end

    always_comb
    begin
        cfg.dec   = (dec_reg == '0) ? DEC_W'(1) : dec_reg;
        cfg.blind = blind_reg;
        for (int i = 0; i < 9; i++)
        begin
            cfg.mat[i] = mat_reg[i];
        end
        cfg.off_n = offn_reg;
        cfg.off_e = offe_reg;
        cfg.off_d = offd_reg;
    end

    a_dec_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && cfg_index == CFG_DECIMATION |=> dec_reg == $past(cfg_data[DEC_W-1:0]))
        else $error("decimation register missed a write");

endmodule

FILE: sv/pcdt_filter.sv
// Point filter: index range and finite checks, pipelined index remainder and
// squared-norm blind-zone test. Depends on pcdt_pkg.
module pcdt_filter
    import pcdt_pkg::*;
#(
    parameter int MAX_PTS = MAX_POINTS
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [IDX_W-1:0] in_index,
    input  point_t           in_point,
    input  logic             in_finite,
    input  cfg_t             cfg,
    output logic             out_valid,
    input  logic             out_ready,
    output point_t           out_point
);

    localparam int NST = REM_STAGES + 1;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        point_t           pt;
        logic [DEC_W-1:0] rem;
        logic [SQ_W-1:0]  sq_f;
        logic [SQ_W-1:0]  sq_l;
        logic [SQ_W-1:0]  sq_u;
        logic             outside;
    } fstage_t;

    fstage_t         st_reg  [NST];
    fstage_t         st_next [NST];
    logic [NST-1:0]  v_reg;
    logic [NST-1:0]  v_next;
    logic [NST-1:0]  ld;

    // Restoring remainder over REM_BITS index bits, MSB first
    function automatic logic [DEC_W-1:0] rem_step(input logic [DEC_W-1:0] rem,
                                                  input logic [REM_BITS-1:0] bits,
                                                  input logic [DEC_W-1:0] den);
        logic [DEC_W:0]   part;
        logic [DEC_W-1:0] acc;
        acc = rem;
        for (int i = REM_BITS - 1; i >= 0; i--)
        begin
            part = {acc, bits[i]};
            if (part >= {1'b0, den})
            begin
                part = part - {1'b0, den};
            end
            acc = part[DEC_W-1:0];
        end
        return acc;
    endfunction

    always_comb
    begin
        ld[NST-1] = !v_reg[NST-1] || out_ready;
        for (int k = NST - 2; k >= 0; k--)
        begin
            ld[k] = !v_reg[k] || ld[k+1];
        end
    end

    always_comb
    begin
        logic signed [2*COORD_W-1:0] pf, pl, pu;
        logic [SQSUM_W-1:0]          sum;

        st_next[0].idx     = in_index;
        st_next[0].pt      = in_point;
        st_next[0].rem     = '0;
        st_next[0].sq_f    = '0;
        st_next[0].sq_l    = '0;
        st_next[0].sq_u    = '0;
        st_next[0].outside = 1'b0;
        v_next[0] = in_valid && in_finite &&
                    ({{(PT_CMP_W-IDX_W){1'b0}}, in_index} < PT_CMP_W'(MAX_PTS));

        for (int k = 0; k < NST - 1; k++)
        begin
            st_next[k+1]     = st_reg[k];
            st_next[k+1].rem = rem_step(st_reg[k].rem,
                                        st_reg[k].idx[IDX_W-1-k*REM_BITS -: REM_BITS],
                                        cfg.dec);
            pf  = $signed(st_reg[k].pt.f) * $signed(st_reg[k].pt.f);
            pl  = $signed(st_reg[k].pt.l) * $signed(st_reg[k].pt.l);
            pu  = $signed(st_reg[k].pt.u) * $signed(st_reg[k].pt.u);
            sum = {1'b0, st_reg[k].sq_f} + {1'b0, st_reg[k].sq_l} + {1'b0, st_reg[k].sq_u};
            if (k == 0)
            begin
                st_next[k+1].sq_f = pf[SQ_W-1:0];
                st_next[k+1].sq_l = pl[SQ_W-1:0];
                st_next[k+1].sq_u = pu[SQ_W-1:0];
            end
            if (k == 1)
            begin
                st_next[k+1].outside = sum > {{(SQSUM_W-BLIND_W){1'b0}}, cfg.blind};
            end
            if (k == NST - 2)
            begin
                // drop off-grid and blind-zone points here
                v_next[k+1] = v_reg[k] && (st_next[k+1].rem == '0) && st_reg[k].outside;
            end
            else
            begin
                v_next[k+1] = v_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NST; k++)
            begin
                if (ld[k])
                begin
                    v_reg[k] <= v_next[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NST; k++)
        begin
            if (ld[k])
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    assign in_ready  = ld[0];
    assign out_valid = v_reg[NST-1];
    assign out_point = st_reg[NST-1].pt;

    a_kept_ok: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[NST-1] |-> (st_reg[NST-1].rem == '0) && st_reg[NST-1].outside)
        else $error("filter passed a point that should be dropped");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !ld[0] |-> &v_reg)
        else $error("filter stalled input with a bubble in flight");

endmodule

FILE: sv/pcdt_xform.sv
// Rigid transform pipeline: matrix multiply, offset add, Q.30 rounding,
// NED to ENU swap and 24-bit saturation. Depends on pcdt_pkg.
module pcdt_xform
    import pcdt_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  point_t                    in_point,
    input  cfg_t                      cfg,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [COORD_W-1:0] out_east,
    output logic signed [COORD_W-1:0] out_north,
    output logic signed [COORD_W-1:0] out_up
);

    localparam int NST = 4;
    localparam logic signed [SUM_W-1:0] HALF   = SUM_W'(1) <<< (FRAC_W - 1);
    localparam logic signed [RND_W-1:0] SAT_HI = (RND_W'(1) <<< (COORD_W - 1)) - RND_W'(1);
    localparam logic signed [RND_W-1:0] SAT_LO = -(RND_W'(1) <<< (COORD_W - 1));

    logic [NST-1:0] v_reg;
    logic [NST-1:0] ld;

    logic signed [VEC_W-1:0]   vec [3];
    logic signed [PROD_W-1:0]  prod_reg  [9];
    logic signed [PROD_W-1:0]  prod_next [9];
    logic signed [SUM_W-1:0]   pair_reg  [3];
    logic signed [SUM_W-1:0]   pair_next [3];
    logic signed [SUM_W-1:0]   part_reg  [3];
    logic signed [SUM_W-1:0]   part_next [3];
    logic signed [RND_W-1:0]   rnd_reg   [3];
    logic signed [RND_W-1:0]   rnd_next  [3];
    logic signed [OFF_W-1:0]   off [3];
    logic signed [SUM_W-1:0]   tot [3];
    logic signed [RND_W-1:0]   up_neg;
    logic signed [COORD_W-1:0] east_reg, north_reg, up_reg;

    function automatic logic signed [COORD_W-1:0] sat(input logic signed [RND_W-1:0] v);
        if (v > SAT_HI)
        begin
            return {1'b0, {(COORD_W-1){1'b1}}};
        end
        else if (v < SAT_LO)
        begin
            return {1'b1, {(COORD_W-1){1'b0}}};
        end
        return v[COORD_W-1:0];
    endfunction

    always_comb
    begin
        ld[NST-1] = !v_reg[NST-1] || out_ready;
        for (int k = NST - 2; k >= 0; k--)
        begin
            ld[k] = !v_reg[k] || ld[k+1];
        end
    end

    // FLU to FRD: negate left and up
    assign vec[0] = {in_point.f[COORD_W-1], in_point.f};
    assign vec[1] = -$signed({in_point.l[COORD_W-1], in_point.l});
    assign vec[2] = -$signed({in_point.u[COORD_W-1], in_point.u});

    assign off[0] = cfg.off_n;
    assign off[1] = cfg.off_e;
    assign off[2] = cfg.off_d;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                prod_next[i*3+j] = $signed(cfg.mat[i*3+j]) * vec[j];
            end
            pair_next[i] = prod_reg[i*3] + prod_reg[i*3+1];
            part_next[i] = prod_reg[i*3+2] +
                           $signed({{(SUM_W-OFF_W-FRAC_W){off[i][OFF_W-1]}},
                                    off[i], {FRAC_W{1'b0}}});
            // round half toward plus infinity, then floor shift
            tot[i]      = pair_reg[i] + part_reg[i] + HALF;
            rnd_next[i] = tot[i][SUM_W-1:FRAC_W];
        end
    end

    assign up_neg = -rnd_reg[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (ld[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NST; k++)
            begin
                if (ld[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            for (int i = 0; i < 9; i++)
            begin
                prod_reg[i] <= prod_next[i];
            end
        end
        if (ld[1])
        begin
            for (int i = 0; i < 3; i++)
            begin
                pair_reg[i] <= pair_next[i];
                part_reg[i] <= part_next[i];
            end
        end
        if (ld[2])
        begin
            for (int i = 0; i < 3; i++)
            begin
                rnd_reg[i] <= rnd_next[i];
            end
        end
        if (ld[3])
        begin
            east_reg  <= sat(rnd_reg[1]);
            north_reg <= sat(rnd_reg[0]);
            up_reg    <= sat(up_neg);
        end
    end

    assign in_ready  = ld[0];
    assign out_valid = v_reg[NST-1];
    assign out_east  = east_reg;
    assign out_north = north_reg;
    assign out_up    = up_reg;

    a_round_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[2] && !ld[2] |=> v_reg[2] && $stable(rnd_reg[0]) && $stable(rnd_reg[2]))
        else $error("rounding stage lost a stalled word");

endmodule

FILE: sv/point_cloud_decimate_transform.sv
// Top level of the lidar point decimate and rigid transform block.
// Depends on pcdt_pkg, pcdt_cfg, pcdt_filter and pcdt_xform.
//
// Points arrive on s_axis, one word per point; kept points leave on m_axis as
// ENU coordinates in 1/1024 m, saturated to 24 bits. Dropped points (off the
// decimation grid, not finite, index out of range, or not outside the blind
// radius) produce no output word. Write cfg_we/cfg_index/cfg_data only while
// no points are in flight; a quaternion write reaches the rotation matrix through
// the registered quaternion products, which the point pipeline covers.
// Throughput: one point per cycle while m_axis_tready stays high. The path from
// acceptance to m_axis_tvalid runs through an input register, five index
// remainder stages of four quotient bits each (the squared-norm test rides in
// the first two), and a four-stage multiply, add, round and saturate path.
// Stall: every stage carries a valid bit and loads only when it is empty or
// its successor advances, so a low m_axis_tready holds words in place while
// empty stages still fill; s_axis_tready drops only when every stage is full.
// Reset: rst_n clears all valid bits and restores register defaults
// (decimation 3, blind radius squared 262144, identity quaternion, zero
// offsets).
module point_cloud_decimate_transform
    import pcdt_pkg::*;
#(
    parameter int MAX_PTS = MAX_POINTS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // slave stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [95:0]           s_axis_tdata,  // point_index[19:0], point_forward[43:20],
                                                 // point_left[67:44], point_upward[91:68]
    input  logic                  s_axis_tuser,  // point_finite
    // master stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [71:0]           m_axis_tdata,  // out_east[23:0], out_north[47:24],
                                                 // out_up[71:48]
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t             cfg;
    point_t           in_point;
    point_t           flt_point;
    logic             flt_valid;
    logic             xf_ready;
    logic [IDX_W-1:0] in_index;

    logic signed [COORD_W-1:0] out_east, out_north, out_up;

    // Unpack the input word
    assign in_index   = s_axis_tdata[IDX_W-1:0];
    assign in_point.f = s_axis_tdata[IDX_W +: COORD_W];
    assign in_point.l = s_axis_tdata[IDX_W + COORD_W +: COORD_W];
    assign in_point.u = s_axis_tdata[IDX_W + 2*COORD_W +: COORD_W];

    pcdt_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Drop points before spending multipliers on them
    pcdt_filter #(
        .MAX_PTS   (MAX_PTS)
    ) u_filter (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_index  (in_index),
        .in_point  (in_point),
        .in_finite (s_axis_tuser),
        .cfg       (cfg),
        .out_valid (flt_valid),
        .out_ready (xf_ready),
        .out_point (flt_point)
    );

    pcdt_xform u_xform (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (flt_valid),
        .in_ready  (xf_ready),
        .in_point  (flt_point),
        .cfg       (cfg),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_east  (out_east),
        .out_north (out_north),
        .out_up    (out_up)
    );

    // Pack the output word, east lowest
    assign m_axis_tdata = {out_up, out_north, out_east};

endmodule

FILE: test/testbench.sv
// Self-checking testbench for point_cloud_decimate_transform: directed table,
// then randomized register settings and point streams, scored against a local predictor.
// Depends on pcdt_pkg and the point_cloud_decimate_transform RTL.
module testbench;
    import pcdt_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int MAX_GAP      = 13;
    localparam int DRAIN_CYCLES = 16;    // drain pad, longer than the pipeline
    localparam int HOLD_CYCLES  = 150;   // long sink stall, far deeper than the pipeline
    localparam int PHASES       = 10;
    localparam int PHASE_POINTS = 104;
    localparam int PAD_W        = 96 - IDX_W - 3 * COORD_W;

    localparam longint ONE_Q30  = 64'sd1 <<< 30;
    localparam longint HALF_Q30 = 64'sd1 <<< 29;
    localparam longint OUT_HI   = 64'sd8388607;
    localparam longint OUT_LO   = -64'sd8388608;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;

    // Indexes past the last register; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic signed [COORD_W-1:0] east;
        logic signed [COORD_W-1:0] north;
        logic signed [COORD_W-1:0] up;
    } enu_t;

    // Per-word note from the sender: a typed expectation, or defer to the predictor
    typedef struct packed {
        logic preset;
        logic keep;
        enu_t pos;
    } preset_t;

    typedef struct packed {
        logic [IDX_W-1:0]          idx;
        logic signed [COORD_W-1:0] fwd;
        logic signed [COORD_W-1:0] lft;
        logic signed [COORD_W-1:0] upw;
        logic                      finite;
        logic                      preset;
        logic                      keep;
        logic signed [COORD_W-1:0] east;
        logic signed [COORD_W-1:0] north;
        logic signed [COORD_W-1:0] up;
    } stimulus_row_t;

    localparam int DIRECTED_ROWS = 17;

    // Rows marked preset carry the output read straight off the reset setting:
    // decimation 3, blind radius 0.5 m, identity rotation, zero offset. There
    // east = -left, north = forward, up = upward.
    stimulus_row_t directed_rows [DIRECTED_ROWS] = '{
        '{20'd0, 24'sd1024, 24'sd0, 24'sd0, 1'b1, 1'b1, 1'b1, 24'sd0, 24'sd1024, 24'sd0},
        '{20'd3, 24'sd0, 24'sd2048, -24'sd4096, 1'b1, 1'b1, 1'b1,
          -24'sd2048, 24'sd0, -24'sd4096},
        // both saturation rails, east wraps past the top and must clamp
        '{20'd6, COORD_MAX, COORD_MIN, COORD_MIN, 1'b1, 1'b1, 1'b1,
          COORD_MAX, COORD_MAX, COORD_MIN},
        '{20'd9, COORD_MIN, COORD_MAX, COORD_MAX, 1'b1, 1'b1, 1'b1,
          -24'sd8388607, COORD_MIN, COORD_MAX},
        // off the decimation grid
        '{20'd1, 24'sd5000, 24'sd5000, 24'sd5000, 1'b1, 1'b1, 1'b0, 24'sd0, 24'sd0, 24'sd0},
        '{20'd2, 24'sd5000, 24'sd5000, 24'sd5000, 1'b1, 1'b1, 1'b0, 24'sd0, 24'sd0, 24'sd0},
        // not finite
        '{20'd12, 24'sd5000, 24'sd0, 24'sd0, 1'b0, 1'b1, 1'b0, 24'sd0, 24'sd0, 24'sd0},
        // exactly on the blind radius: dropped; one unit beyond: kept
        '{20'd15, 24'sd512, 24'sd0, 24'sd0, 1'b1, 1'b1, 1'b0, 24'sd0, 24'sd0, 24'sd0},
        '{20'd18, 24'sd513, 24'sd0, 24'sd0, 1'b1, 1'b1, 1'b1, 24'sd0, 24'sd513, 24'sd0},
        '{20'd21, 24'sd0, 24'sd0, 24'sd0, 1'b1, 1'b1, 1'b0, 24'sd0, 24'sd0, 24'sd0},
        '{20'd33, -24'sd1, 24'sd1, -24'sd1, 1'b1, 1'b1, 1'b0, 24'sd0, 24'sd0, 24'sd0},
        // highest index, a multiple of three
        '{20'hFFFFF, -24'sd3000, 24'sd7, -24'sd1, 1'b1, 1'b1, 1'b1,
          -24'sd7, -24'sd3000, -24'sd1},
        '{20'd30, 24'sh555555, -24'sh2AAAAA, 24'sh123456, 1'b1, 1'b1, 1'b1,
          24'sh2AAAAA, 24'sh555555, 24'sh123456},
        '{20'h55555, 24'sd100000, -24'sd200000, 24'sd300000, 1'b1, 1'b0, 1'b0,
          24'sd0, 24'sd0, 24'sd0},
        '{20'hAAAAA, -24'sd100000, 24'sd200000, -24'sd300000, 1'b1, 1'b0, 1'b0,
          24'sd0, 24'sd0, 24'sd0},
        '{20'd24, 24'sh2AAAAA, 24'sh555555, -24'sh123456, 1'b1, 1'b0, 1'b0,
          24'sd0, 24'sd0, 24'sd0},
        '{20'd27, 24'sd700, -24'sd300, 24'sd0, 1'b1, 1'b1, 1'b1, 24'sd300, 24'sd700, 24'sd0}
    };

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [95:0]           s_axis_tdata  = '0;   // point_index[19:0], point_forward[43:20],
                                                 // point_left[67:44], point_upward[91:68]
    logic                  s_axis_tuser  = 1'b0; // point_finite
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [71:0]           m_axis_tdata;         // out_east[23:0], out_north[47:24],
                                                 // out_up[71:48]
    logic                  cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;

    // Shadow copy of the register file
    logic [DEC_W-1:0]        dec_cfg;
    logic [BLIND_W-1:0]      blind_cfg;
    logic [QUAT_W-1:0]       quat_cfg;
    logic signed [OFF_W-1:0] north_cfg;
    logic signed [OFF_W-1:0] east_cfg;
    logic signed [OFF_W-1:0] down_cfg;

    preset_t preset_notes [$];
    enu_t    enu_expected [$];

    int  fail_count     = 0;
    int  points_in      = 0;
    int  points_out     = 0;
    int  settings_used  = 1;
    bit  sender_steady  = 1'b0;
    bit  sink_steady    = 1'b0;
    bit  hold_off_request = 1'b0;

    point_cloud_decimate_transform u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #HALF_PERIOD clk = ~clk;
    end

    // Round a Q.30 sum to whole units, ties toward plus infinity
    function automatic longint round_q30(input longint v);
        return (v + HALF_Q30) >>> 30;
    endfunction

    function automatic logic signed [COORD_W-1:0] clamp_coord(input longint v);
        if (v > OUT_HI)
            return COORD_MAX;
        if (v < OUT_LO)
            return COORD_MIN;
        return v[COORD_W-1:0];
    endfunction

    // Decide whether a point survives and where it lands in ENU
    function automatic logic transform_point(input logic [IDX_W-1:0] idx, input point_t pt,
                                             input logic finite, output enu_t pos);
        longint dec, f, r, d, sq, qw, qx, qy, qz;
        longint m00, m01, m02, m10, m11, m12, m20, m21, m22;
        longint n, e, dn;
        pos = '0;
        dec = (dec_cfg == '0) ? 64'sd1 : longint'(dec_cfg);
        if (longint'(idx) >= MAX_POINTS || longint'(idx) % dec != 0 || !finite)
            return 1'b0;

        // FLU to FRD: negate left and up
        f  = pt.f;
        r  = pt.l;
        r  = -r;
        d  = pt.u;
        d  = -d;
        sq = f * f + r * r + d * d;
        if (sq <= longint'(blind_cfg))
            return 1'b0;

        qw = $signed(quat_cfg[63:48]);
        qx = $signed(quat_cfg[47:32]);
        qy = $signed(quat_cfg[31:16]);
        qz = $signed(quat_cfg[15:0]);

        m00 = ONE_Q30 - 2 * (qy * qy + qz * qz);
        m01 = 2 * (qx * qy - qw * qz);
        m02 = 2 * (qx * qz + qw * qy);
        m10 = 2 * (qx * qy + qw * qz);
        m11 = ONE_Q30 - 2 * (qx * qx + qz * qz);
        m12 = 2 * (qy * qz - qw * qx);
        m20 = 2 * (qx * qz - qw * qy);
        m21 = 2 * (qy * qz + qw * qx);
        m22 = ONE_Q30 - 2 * (qx * qx + qy * qy);

        n  = m00 * f + m01 * r + m02 * d + longint'(north_cfg) * ONE_Q30;
        e  = m10 * f + m11 * r + m12 * d + longint'(east_cfg) * ONE_Q30;
        dn = m20 * f + m21 * r + m22 * d + longint'(down_cfg) * ONE_Q30;

        // NED to ENU
        pos.east  = clamp_coord(round_q30(e));
        pos.north = clamp_coord(round_q30(n));
        pos.up    = clamp_coord(-round_q30(dn));
        return 1'b1;
    endfunction

    function automatic int sender_gap();
        return sender_steady ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    function automatic int sink_gap();
        return sink_steady ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // Full range half the time, near the sensor often, rails now and then
    function automatic logic signed [COORD_W-1:0] random_coord();
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick < 10)
            return COORD_W'($urandom);
        if (pick < 17)
            return COORD_W'($urandom_range(0, 16383) - 8192);
        if (pick == 17)
            return COORD_MAX;
        if (pick == 18)
            return COORD_MIN;
        return '0;
    endfunction

    // Mostly on the decimation grid so that points reach the transform
    task automatic random_point(output logic [IDX_W-1:0] idx, output point_t pt,
                                output logic finite);
        int unsigned dec;
        dec = (dec_cfg == '0) ? 1 : int'(dec_cfg);
        if ($urandom_range(0, 3) != 0)
            idx = IDX_W'(dec * $urandom_range(0, (MAX_POINTS - 1) / dec));
        else
            idx = IDX_W'($urandom);
        pt.f   = random_coord();
        pt.l   = random_coord();
        pt.u   = random_coord();
        finite = ($urandom_range(0, 9) != 0);
    endtask

    // Offer one word; keep tvalid high across back-to-back words
    task automatic send_point(input logic [IDX_W-1:0] idx, input point_t pt,
                              input logic finite, input preset_t note);
        int gap;
        gap = sender_gap();
        preset_notes.push_back(note);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{PAD_W{1'b0}}, pt.u, pt.l, pt.f, idx};
        s_axis_tuser  <= finite;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    // Hold the sender until every kept point is out, then let dropped ones flush
    task automatic wait_for_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (enu_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        case (index)
            CFG_DECIMATION:   dec_cfg   = value[DEC_W-1:0];
            CFG_BLIND_RADIUS: blind_cfg = value[BLIND_W-1:0];
            CFG_QUATERNION:   quat_cfg  = value;
            CFG_OFF_NORTH:    north_cfg = value[OFF_W-1:0];
            CFG_OFF_EAST:     east_cfg  = value[OFF_W-1:0];
            CFG_OFF_DOWN:     down_cfg  = value[OFF_W-1:0];
            default: ;
        endcase
    endtask

    // Pick a register setting per phase; the first three pin the extremes
    task automatic apply_setting(input int phase);
        logic [DEC_W-1:0]   dec;
        logic [BLIND_W-1:0] blind;
        logic [QUAT_W-1:0]  quat;
        logic [OFF_W-1:0]   off_n, off_e, off_d;
        case (phase)
            1:
            begin
                // zero decimation means keep every index
                dec   = '0;
                blind = '0;
                quat  = QUAT_RESET;
                off_n = '0;
                off_e = '0;
                off_d = '0;
            end
            2:
            begin
                dec   = 8'd1;
                blind = '1;
                quat  = 64'h8000_8000_8000_8000;
                off_n = 32'h7FFF_FFFF;
                off_e = 32'h7FFF_FFFF;
                off_d = 32'h7FFF_FFFF;
            end
            3:
            begin
                dec   = 8'hFF;
                blind = BLIND_W'($urandom_range(0, 1 << 26));
                quat  = 64'h7FFF_7FFF_7FFF_7FFF;
                off_n = 32'h8000_0000;
                off_e = 32'h8000_0000;
                off_d = 32'h8000_0000;
            end
            default:
            begin
                dec   = DEC_W'($urandom_range(1, 12));
                blind = (phase % 2 == 0) ? {2'($urandom), 32'($urandom)}
                                         : BLIND_W'($urandom_range(0, 1 << 30));
                quat  = {$urandom, $urandom};
                if (phase == 9)
                begin
                    off_n = $urandom;
                    off_e = $urandom;
                    off_d = $urandom;
                end
                else
                begin
                    off_n = OFF_W'($urandom_range(0, 1 << 23) - (1 << 22));
                    off_e = OFF_W'($urandom_range(0, 1 << 23) - (1 << 22));
                    off_d = OFF_W'($urandom_range(0, 1 << 23) - (1 << 22));
                end
            end
        endcase
        write_reg(CFG_SPARE_LO, {$urandom, $urandom});
        write_reg(CFG_OFF_DOWN, {{(CFG_DATA_W - OFF_W){1'b0}}, off_d});
        write_reg(CFG_QUATERNION, quat);
        write_reg(CFG_DECIMATION, {{(CFG_DATA_W - DEC_W){1'b0}}, dec});
        write_reg(CFG_OFF_NORTH, {{(CFG_DATA_W - OFF_W){1'b0}}, off_n});
        write_reg(CFG_BLIND_RADIUS, {{(CFG_DATA_W - BLIND_W){1'b0}}, blind});
        write_reg(CFG_OFF_EAST, {{(CFG_DATA_W - OFF_W){1'b0}}, off_e});
        write_reg(CFG_SPARE_HI, {$urandom, $urandom});
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Score both streams at the clock edge; values seen here are the pre-edge ones
    always @(posedge clk)
    begin
        preset_t note;
        point_t  pt;
        enu_t    want;
        enu_t    got;
        logic    keep;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                points_in++;
                note = preset_notes.pop_front();
                pt.f = s_axis_tdata[43:20];
                pt.l = s_axis_tdata[67:44];
                pt.u = s_axis_tdata[91:68];
                if (note.preset)
                begin
                    keep = note.keep;
                    want = note.pos;
                end
                else
                begin
                    keep = transform_point(s_axis_tdata[IDX_W-1:0], pt, s_axis_tuser, want);
                end
                if (keep)
                    enu_expected.push_back(want);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                points_out++;
                got.east  = m_axis_tdata[23:0];
                got.north = m_axis_tdata[47:24];
                got.up    = m_axis_tdata[71:48];
                if (enu_expected.size() == 0)
                begin
                    $error("unexpected output word %h", m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    want = enu_expected.pop_front();
                    if (got.east !== want.east)
                    begin
                        $error("out_east: expected %0d, got %0d", want.east, got.east);
                        fail_count++;
                    end
                    if (got.north !== want.north)
                    begin
                        $error("out_north: expected %0d, got %0d", want.north, got.north);
                        fail_count++;
                    end
                    if (got.up !== want.up)
                    begin
                        $error("out_up: expected %0d, got %0d", want.up, got.up);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Sink: stall a random count per word, or hold off for a long stretch on request
    initial
    begin : result_sink
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                stall = HOLD_CYCLES;
            end
            else
            begin
                stall = sink_gap();
            end
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    initial
    begin : stimulus
        logic [IDX_W-1:0] idx;
        point_t           pt;
        logic             finite;
        preset_t          note;

        dec_cfg   = DEC_RESET;
        blind_cfg = BLIND_RESET;
        quat_cfg  = QUAT_RESET;
        north_cfg = '0;
        east_cfg  = '0;
        down_cfg  = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows against the reset setting
        foreach (directed_rows[i])
        begin
            pt.f       = directed_rows[i].fwd;
            pt.l       = directed_rows[i].lft;
            pt.u       = directed_rows[i].upw;
            note.preset    = directed_rows[i].preset;
            note.keep      = directed_rows[i].keep;
            note.pos.east  = directed_rows[i].east;
            note.pos.north = directed_rows[i].north;
            note.pos.up    = directed_rows[i].up;
            send_point(directed_rows[i].idx, pt, directed_rows[i].finite, note);
        end

        // Random phases; phase zero stays on the reset setting
        note = '0;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase > 0)
            begin
                wait_for_idle();
                apply_setting(phase);
            end
            sender_steady = (phase % 3 == 1) || (phase == 4);
            sink_steady   = (phase % 4 == 2);
            // Back up the pipeline: sink holds off while the source streams flat out
            if (phase == 4)
                hold_off_request = 1'b1;
            repeat (PHASE_POINTS)
            begin
                random_point(idx, pt, finite);
                send_point(idx, pt, finite, note);
            end
        end

        wait_for_idle();
        $display("covered %0d points in and %0d checked words out over %0d register settings",
                 points_in, points_out, settings_used);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin : watchdog
        #3000000;
        $display("timeout waiting for transformed points");
        $display("end of test: mismatches");
        $finish;
    end

endmodule
